// File: hw/rtl/sti_pkg.sv
// sti_pkg: shared types and codes for the sorted table block
// no dependencies; imported by sti_cmp, the top level and the checker
`default_nettype none
package sti_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
    logic hit;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/sti_cmp.sv
// sti_cmp: shared compare unit for the table scan
// depends on sti_pkg
`default_nettype none
module sti_cmp (
  input  wire logic                         mode,
  input  wire logic [sti_pkg::VALUE_W-1:0]  entry,
  input  wire logic [sti_pkg::VALUE_W-1:0]  value,
  output sti_pkg::cmp_res_t                 res
);
  import sti_pkg::*;

  always_comb begin
    res.lt  = $signed(entry) < $signed(value);
    res.eq  = (entry == value);
    // insert stops at first entry not smaller, remove at first equal
    res.hit = (mode == MODE_REMOVE) ? res.eq : !res.lt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sorted_table_insert_remove.sv
// sorted_table_insert_remove: ascending table of signed words with insert and remove
// sequencing: each entry compared passes S_SCAN and S_CMP, each entry shifted passes S_UP and
//   S_UPWR or S_DN and S_DNWR, then S_DONE loads the output register; a dropped insert goes
//   straight to S_DONE; the run time is set by the shared compare unit and the single
//   read port of the table memory
// throughput: one word at a time; in_stall stays high until the result is registered,
//   the next word can be taken in the cycle after
// reset: rst (synchronous, active high) empties the table and clears the handshake;
//   table contents are not cleared, entries at or above the count are never read
`default_nettype none
module sorted_table_insert_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          mode,
  input  wire logic [sti_pkg::VALUE_W-1:0]   value,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [sti_pkg::STATUS_W-1:0]  status,
  output      logic [sti_pkg::POS_W-1:0]     position,
  output      logic [sti_pkg::COUNT_W-1:0]   count
);
  import sti_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // issue read of entry ptr
  localparam logic [2:0] S_CMP  = 3'd2;  // compare read data with value
  localparam logic [2:0] S_UP   = 3'd3;  // insert: read ptr-1 or place value
  localparam logic [2:0] S_UPWR = 3'd4;  // insert: move entry up to ptr
  localparam logic [2:0] S_DN   = 3'd5;  // remove: read ptr+1 or finish
  localparam logic [2:0] S_DNWR = 3'd6;  // remove: move entry down to ptr
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  logic [2:0]          state;
  logic                mode_r;
  logic [VALUE_W-1:0]  val_r;
  logic [CW-1:0]       occupied;
  logic [CW-1:0]       ptr;
  logic [AW-1:0]       pos;
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_position;
  logic [COUNT_W-1:0]  res_count;

  // table memory, one read and one write port
  logic [VALUE_W-1:0]  mem [CAPACITY];
  logic [VALUE_W-1:0]  rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  cmp_res_t cmp;

  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic          at_end;
  logic          at_pos;
  logic          dn_last;
  logic          out_load;

  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign at_end  = (ptr == occupied);
  assign at_pos  = (ptr == CW'(pos));
  assign dn_last = (ptr_inc >= occupied);

  // result moves into the output register once that register is free
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign in_stall = (state != S_IDLE);

  sti_cmp u_cmp (
    .mode  (mode_r),
    .entry (rd_data),
    .value (val_r),
    .res   (cmp)
  );

  // memory strobes follow the sequencer state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SCAN: begin
        rd_en = !at_end;
      end
      S_UP: begin
        rd_en   = !at_pos;
        rd_addr = ptr_dec[AW-1:0];
        // value lands in its slot once everything above has moved up
        wr_en   = at_pos;
        wr_addr = pos;
        wr_data = val_r;
      end
      S_UPWR: begin
        wr_en = 1'b1;
      end
      S_DN: begin
        rd_en   = !dn_last;
        rd_addr = ptr_inc[AW-1:0];
      end
      S_DNWR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupied  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            val_r  <= value;
            ptr    <= '0;
            if (mode == MODE_INSERT && occupied == FULL_CNT) begin
              // full table, insert dropped
              res_status   <= ST_FULL;
              res_position <= '0;
              res_count    <= COUNT_W'(occupied);
              state        <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (at_end) begin
            if (mode_r == MODE_INSERT) begin
              // append after all entries
              pos   <= ptr[AW-1:0];
              state <= S_UP;
            end else begin
              res_status   <= ST_NOTFOUND;
              res_position <= '0;
              res_count    <= COUNT_W'(occupied);
              state        <= S_DONE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp.hit) begin
            pos <= ptr[AW-1:0];
            if (mode_r == MODE_INSERT) begin
              ptr   <= occupied;
              state <= S_UP;
            end else begin
              state <= S_DN;
            end
          end else begin
            ptr   <= ptr_inc;
            state <= S_SCAN;
          end
        end
        S_UP: begin
          if (at_pos) begin
            occupied     <= occupied + 1'b1;
            res_status   <= ST_INSERTED;
            res_position <= POS_W'(pos);
            res_count    <= COUNT_W'(occupied + 1'b1);
            state        <= S_DONE;
          end else begin
            state <= S_UPWR;
          end
        end
        S_UPWR: begin
          ptr   <= ptr_dec;
          state <= S_UP;
        end
        S_DN: begin
          if (dn_last) begin
            occupied     <= occupied - 1'b1;
            res_status   <= ST_REMOVED;
            res_position <= POS_W'(pos);
            res_count    <= COUNT_W'(occupied - 1'b1);
            state        <= S_DONE;
          end else begin
            state <= S_DNWR;
          end
        end
        S_DNWR: begin
          ptr   <= ptr_inc;
          state <= S_DN;
        end
        S_DONE: begin
          // wait until the output register is free
          if (out_load) begin
            status   <= res_status;
            position <= res_position;
            count    <= res_count;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sti_checker.sv
// sti_checker: port-level assertions for sorted_table_insert_remove, bound to the top level
// depends on sti_pkg and sorted_table_insert_remove
`default_nettype none
module sti_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          mode,
  input wire logic [sti_pkg::VALUE_W-1:0]   value,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [sti_pkg::STATUS_W-1:0]  status,
  input wire logic [sti_pkg::POS_W-1:0]     position,
  input wire logic [sti_pkg::COUNT_W-1:0]   count
);
  import sti_pkg::*;

  localparam logic SMALL_CAP = (CAPACITY < 32);

  // one word at a time: accepting a word closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accepting a word");

  // no position reported when nothing was acted on
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NOTFOUND || status == ST_FULL)) |-> (position == '0))
    else $error("nonzero position on not-found or full result");

  // an insert leaves at least one entry; checked only for CAPACITY below 32
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (SMALL_CAP && out_valid && status == ST_INSERTED) |-> (count != '0))
    else $error("insert reported an empty table");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(position)
                                  && $stable(count)))
    else $error("result word changed while stalled");

endmodule

bind sorted_table_insert_remove sti_checker #(.CAPACITY(CAPACITY)) u_sti_checker (.*);
`default_nettype wire
